### hdl/slfd_pkg.sv
`timescale 1ns / 1ps
// Package for the segment LCD frame driver: word types, function codes,
// command struct and the glyph ROM. No dependencies.
package slfd_pkg;

    localparam int POSITIONS_DEF   = 8;
    localparam int GLYPH_COUNT_DEF = 40;
    localparam int WORD_BITS_DEF   = 9;
    localparam int FRAME_BITS      = 9;

    typedef enum logic [1:0] {
        FUNC_RAW   = 2'd0,
        FUNC_GLYPH = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] position;
        logic [8:0] symbol_value;
        logic [5:0] glyph_index;
        logic       dot_on;
        logic       mark_on;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame_word;
        logic                  load_strobe;
    } t_out_item;

    typedef struct packed {
        logic update;
        logic load;
        logic zero_word;
        logic strobe;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [8:0] glyph_rom(input logic [5:0] idx);
        logic [8:0] g;
        case (idx)
            6'd0:  g = 9'd444;
            6'd1:  g = 9'd12;
            6'd2:  g = 9'd472;
            6'd3:  g = 9'd348;
            6'd4:  g = 9'd108;
            6'd5:  g = 9'd372;
            6'd6:  g = 9'd500;
            6'd7:  g = 9'd28;
            6'd8:  g = 9'd508;
            6'd9:  g = 9'd380;
            6'd10: g = 9'd0;
            6'd11: g = 9'd252;
            6'd12: g = 9'd484;
            6'd13: g = 9'd432;
            6'd14: g = 9'd460;
            6'd15: g = 9'd496;
            6'd16: g = 9'd240;
            6'd17: g = 9'd436;
            6'd18: g = 9'd236;
            6'd19: g = 9'd160;
            6'd20: g = 9'd268;
            6'd21: g = 9'd244;
            6'd22: g = 9'd416;
            6'd23: g = 9'd148;
            6'd24: g = 9'd196;
            6'd25: g = 9'd248;
            6'd26: g = 9'd124;
            6'd27: g = 9'd192;
            6'd28: g = 9'd372;
            6'd29: g = 9'd480;
            6'd30: g = 9'd428;
            6'd31: g = 9'd388;
            6'd32: g = 9'd296;
            6'd33: g = 9'd364;
            6'd34: g = 9'd408;
            6'd35: g = 9'd188;
            6'd36: g = 9'd120;
            6'd37: g = 9'd64;
            6'd38: g = 9'd452;
            6'd39: g = 9'd2;
            default: g = 9'd0;
        endcase
        return g;
    endfunction

endpackage

### hdl/slfd_ctrl.sv
`timescale 1ns / 1ps
// Controller of the segment LCD frame driver: accepts input words and
// sequences the frame words. Depends on slfd_pkg.
module slfd_ctrl
    import slfd_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF,
    localparam int CNT_W = $clog2(POSITIONS + 2),
    localparam int IDX_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_status          i_status,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_idx
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(POSITIONS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] rd_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign rd_pos = LAST - r_cnt;
    assign o_idx  = rd_pos[IDX_W-1:0];

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_in_ready      = 1'b0;
        o_cmd.update    = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.zero_word = (r_cnt < CNT_W'(2));
        o_cmd.strobe    = (r_cnt == LAST);
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.update = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = r_cnt + CNT_W'(1);
                    if (r_cnt == LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/slfd_datapath.sv
`timescale 1ns / 1ps
// Datapath of the segment LCD frame driver: position store, glyph lookup
// and output register. Depends on slfd_pkg.
module slfd_datapath
    import slfd_pkg::*;
#(
    parameter int POSITIONS   = POSITIONS_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    localparam int IDX_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_item,
    input  t_cmd             i_cmd,
    input  logic [IDX_W-1:0] i_idx,
    output t_status          o_status,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out_item        o_out_item
);

    logic [WORD_BITS-1:0] r_store [POSITIONS];
    logic                 r_out_valid;
    t_out_item            r_out_item;
    logic [8:0]           glyph_word;
    logic [8:0]           glyph_sum;
    logic [WORD_BITS-1:0] wr_word;
    logic [WORD_BITS-1:0] rd_word;

    always_comb begin
        glyph_word = '0;
        if (int'(i_in_item.glyph_index) < GLYPH_COUNT) begin
            glyph_word = glyph_rom(i_in_item.glyph_index);
        end
        glyph_sum = glyph_word + {8'd0, i_in_item.dot_on} + {7'd0, i_in_item.mark_on, 1'b0};
    end

    always_comb begin
        if (i_in_item.func == FUNC_GLYPH) begin
            wr_word = WORD_BITS'(glyph_sum);
        end else begin
            wr_word = WORD_BITS'(i_in_item.symbol_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POSITIONS; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_cmd.update) begin
            unique case (i_in_item.func) inside
                FUNC_RAW, FUNC_GLYPH: begin
                    for (int i = 0; i < POSITIONS; i++) begin
                        if (int'(i_in_item.position) == i) begin
                            r_store[i] <= wr_word;
                        end
                    end
                end
                FUNC_CLEAR: begin
                    for (int i = 0; i < POSITIONS; i++) begin
                        r_store[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign rd_word = r_store[i_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_item.frame_word  <= i_cmd.zero_word ? 9'd0 : rd_word[8:0];
            r_out_item.load_strobe <= i_cmd.strobe;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

endmodule

### hdl/segment_lcd_frame_driver.sv
`timescale 1ns / 1ps
// Top level of the segment LCD frame driver: joins controller and datapath.
// Depends on slfd_pkg, slfd_ctrl and slfd_datapath.
//
// Usage:
//   The input channel (i_in_valid, o_in_ready, i_in_item) takes one command
//   word: a raw write, a glyph write, a clear of all positions, or an unused
//   code that leaves the store as it is. The store is updated at the edge that
//   accepts the word. The output channel (o_out_valid, i_out_ready, o_out_item)
//   then delivers POSITIONS + 2 frame words: two zero words, then positions
//   POSITIONS-1 down to 0. load_strobe is high on the last word only.
//   After acceptance the controller enters its emit state, in which one frame
//   word is loaded into the output register each cycle in which it is empty
//   or being taken, in the order set by the frame word counter.
//   o_in_ready rises again once the last word has entered the output
//   register, so the next command may be accepted while it still waits.
//   A stalled receiver holds the output word and pauses the frame sequence.
//   Reset clears the store to blank, empties the output register and
//   returns the controller to idle.
module segment_lcd_frame_driver
    import slfd_pkg::*;
#(
    parameter int POSITIONS   = POSITIONS_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IDX_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] idx;

    slfd_ctrl #(
        .POSITIONS (POSITIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    slfd_datapath #(
        .POSITIONS   (POSITIONS),
        .GLYPH_COUNT (GLYPH_COUNT),
        .WORD_BITS   (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while a frame is in progress");

    a_no_load_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && cmd.load))
        else $error("frame word loaded while controller idle");

    a_idle_after_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && cmd.strobe) |=> (o_in_ready && o_out_valid && o_out_item.load_strobe))
        else $error("last frame word did not return controller to idle");

endmodule

### verif/slfd_checker.sv
`timescale 1ns / 1ps
// Checker for the segment LCD frame driver: watches both channels, predicts
// every frame word from its own copy of the position store and compares.
// Depends on slfd_pkg.
module slfd_checker
    import slfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int DIGITS = 8;
    localparam int SHAPES = 40;

    logic [8:0] shape_table [SHAPES] = '{
        9'd444, 9'd12,  9'd472, 9'd348, 9'd108, 9'd372, 9'd500, 9'd28,
        9'd508, 9'd380, 9'd0,   9'd252, 9'd484, 9'd432, 9'd460, 9'd496,
        9'd240, 9'd436, 9'd236, 9'd160, 9'd268, 9'd244, 9'd416, 9'd148,
        9'd196, 9'd248, 9'd124, 9'd192, 9'd372, 9'd480, 9'd428, 9'd388,
        9'd296, 9'd364, 9'd408, 9'd188, 9'd120, 9'd64,  9'd452, 9'd2
    };

    logic [8:0] digit_store [DIGITS];
    t_out_item  frame_words_due [$];
    int         fail_count = 0;

    always @(posedge i_clk) begin
        t_out_item  seen;
        t_out_item  due;
        logic [9:0] shape;
        if (!i_rst_n) begin
            for (int p = 0; p < DIGITS; p++) begin
                digit_store[p] = '0;
            end
            frame_words_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen = i_out_item;
                if (frame_words_due.size() == 0) begin
                    $display("%0t: unexpected frame word %0d strobe %0b", $time,
                             seen.frame_word, seen.load_strobe);
                    fail_count++;
                end else begin
                    due = frame_words_due.pop_front();
                    if (seen.frame_word !== due.frame_word) begin
                        $display("%0t: frame_word expected %0d actual %0d", $time,
                                 due.frame_word, seen.frame_word);
                        fail_count++;
                    end
                    if (seen.load_strobe !== due.load_strobe) begin
                        $display("%0t: load_strobe expected %0b actual %0b", $time,
                                 due.load_strobe, seen.load_strobe);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_item.func)
                    FUNC_RAW: begin
                        digit_store[i_in_item.position] = i_in_item.symbol_value;
                    end
                    FUNC_GLYPH: begin
                        shape = '0;
                        if (i_in_item.glyph_index < SHAPES) begin
                            shape = {1'b0, shape_table[i_in_item.glyph_index]};
                        end
                        shape = shape + i_in_item.dot_on + (i_in_item.mark_on ? 10'd2 : 10'd0);
                        digit_store[i_in_item.position] = shape[8:0];
                    end
                    FUNC_CLEAR: begin
                        for (int p = 0; p < DIGITS; p++) begin
                            digit_store[p] = '0;
                        end
                    end
                    default: begin
                    end
                endcase
                frame_words_due.push_back('{frame_word: 9'd0, load_strobe: 1'b0});
                frame_words_due.push_back('{frame_word: 9'd0, load_strobe: 1'b0});
                for (int p = DIGITS - 1; p >= 0; p--) begin
                    frame_words_due.push_back('{frame_word: digit_store[p],
                                                load_strobe: (p == 0)});
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= frame_words_due.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the segment LCD frame driver: clock, reset, command
// stimulus with random idling and the verdict. Depends on slfd_pkg,
// slfd_checker and segment_lcd_frame_driver.
module tb;
    import slfd_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RANDOM_WORDS = 180;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;
    logic      calm = 1'b0;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;

    always #4 i_clk = ~i_clk;

    segment_lcd_frame_driver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    slfd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("segment_lcd_frame_driver test failed");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] func, input logic [2:0] position,
                             input logic [8:0] symbol, input logic [5:0] glyph,
                             input logic dot, input logic mark);
        t_in_item w;
        int       gap;
        w.func         = func;
        w.position     = position;
        w.symbol_value = symbol;
        w.glyph_index  = glyph;
        w.dot_on       = dot;
        w.mark_on      = mark;
        i_in_valid <= 1'b1;
        i_in_item  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 25) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [1:0] func;
        int         r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(FUNC_UNUSED, 3'd0, 9'd0, 6'd0, 1'b0, 1'b0);
        send_word(FUNC_RAW, 3'd0, 9'd511, 6'd63, 1'b1, 1'b1);
        send_word(FUNC_RAW, 3'd7, 9'd341, 6'd0, 1'b0, 1'b0);
        send_word(FUNC_RAW, 3'd3, 9'd170, 6'd21, 1'b1, 1'b0);
        send_word(FUNC_RAW, 3'd4, 9'd0, 6'd42, 1'b0, 1'b1);
        send_word(FUNC_GLYPH, 3'd1, 9'd511, 6'd0, 1'b0, 1'b0);
        send_word(FUNC_GLYPH, 3'd2, 9'd0, 6'd39, 1'b1, 1'b1);
        send_word(FUNC_GLYPH, 3'd5, 9'd0, 6'd40, 1'b1, 1'b0);
        send_word(FUNC_GLYPH, 3'd6, 9'd0, 6'd63, 1'b0, 1'b1);
        send_word(FUNC_GLYPH, 3'd7, 9'd0, 6'd8, 1'b1, 1'b1);
        send_word(FUNC_GLYPH, 3'd0, 9'd0, 6'd10, 1'b0, 1'b0);
        send_word(FUNC_UNUSED, 3'd5, 9'd511, 6'd1, 1'b1, 1'b1);
        send_word(FUNC_CLEAR, 3'd7, 9'd511, 6'd63, 1'b1, 1'b1);
        send_word(FUNC_RAW, 3'd2, 9'd256, 6'd0, 1'b0, 1'b0);
        send_word(FUNC_CLEAR, 3'd0, 9'd0, 6'd0, 1'b0, 1'b0);
        i_in_valid <= 1'b0;
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 60) begin
                calm <= 1'b1;
            end else if (n == 100) begin
                calm <= 1'b0;
            end
            if (n == 130) begin
                i_in_valid <= 1'b0;
                drain();
            end
            r = $urandom_range(99);
            func = (r < 40) ? FUNC_GLYPH : (r < 80) ? FUNC_RAW :
                   (r < 92) ? FUNC_CLEAR : FUNC_UNUSED;
            send_word(func, 3'($urandom), 9'($urandom),
                      ($urandom_range(1) == 0) ? 6'($urandom_range(39)) : 6'($urandom),
                      1'($urandom), 1'($urandom));
        end
        i_in_valid <= 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("segment_lcd_frame_driver test passed");
        end else begin
            $display("segment_lcd_frame_driver test failed");
        end
        $finish;
    end

endmodule
